// ----- hw/rtl/mf3_pkg.sv -----
package mf3_pkg;

	localparam int PIX_W = 8;
	localparam int CFG_W = 13;
	localparam int MIN_WIDTH = 3;
	localparam logic [CFG_W-1:0] LINE_WIDTH_RST = 13'd640;

	// output queue, sized so a new item is taken while two results wait
	localparam int OQ_DEPTH = 8;
	localparam int OQ_PW = $clog2(OQ_DEPTH);
	localparam int OQ_CW = $clog2(OQ_DEPTH + 1);

	typedef logic [PIX_W-1:0] pix_t;

	typedef struct packed {
		pix_t value;
		logic line_end;
	} res_t;

	function automatic pix_t min2(input pix_t a, input pix_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic pix_t max2(input pix_t a, input pix_t b);
		return (a < b) ? b : a;
	endfunction

	function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
		return max2(min2(a, b), min2(max2(a, b), c));
	endfunction

	// median of nine: sort each row of three, then take the largest minimum,
	// the middle median and the smallest maximum, and the median of those
	function automatic pix_t median9(
		input pix_t a0, input pix_t a1, input pix_t a2,
		input pix_t b0, input pix_t b1, input pix_t b2,
		input pix_t c0, input pix_t c1, input pix_t c2
	);
		pix_t lo;
		pix_t mid;
		pix_t hi;
		lo = max2(max2(min2(min2(a0, a1), a2), min2(min2(b0, b1), b2)),
			min2(min2(c0, c1), c2));
		mid = med3(med3(a0, a1, a2), med3(b0, b1, b2), med3(c0, c1, c2));
		hi = min2(min2(max2(max2(a0, a1), a2), max2(max2(b0, b1), b2)),
			max2(max2(c0, c1), c2));
		return med3(lo, mid, hi);
	endfunction

endpackage

// ----- hw/rtl/median_filter_3x3_stream_top.sv -----
// 3x3 median filter over a raster pixel stream, one pixel per item.
// Throughput: one input item per cycle while in_ready is high; in_ready drops as the output
// queue fills. Results come out in order. Path: the line store is read at the take, then the
// median network writes the item's results into the output queue, from which they leave.
// Reset (arst_n low): counters, window and queue clear; line_width goes to 640.
// Line store contents are not cleared.
module median_filter_3x3_stream_top #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [mf3_pkg::CFG_W-1:0]  line_width,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [mf3_pkg::PIX_W-1:0]  pixel_in,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [mf3_pkg::PIX_W-1:0]  pixel_out,
	output logic                       line_end
);
	import mf3_pkg::*;

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;

	logic [CFG_W-1:0] line_width_q;
	logic [AW-1:0]    col_q;
	logic [1:0]       line_cnt_q;

	logic             acc;
	logic [AW-1:0]    cc;
	logic [WW-1:0]    lw_ext;
	logic [WW-1:0]    ew_m1;
	logic             last;

	logic             valid_s1;
	logic             emit1_s1;
	logic             emit2_s1;
	logic             med_en_s1;
	logic [AW-1:0]    c_s1;
	pix_t             px_s1;
	pix_t             old_rd_s1;
	pix_t             new_rd_s1;

	pix_t             older_mem [MAX_WIDTH];
	pix_t             newer_mem [MAX_WIDTH];
	pix_t             win_q [6];
	pix_t             med;

	res_t             oq_q [OQ_DEPTH];
	logic [OQ_PW-1:0] wr_ptr_q;
	logic [OQ_PW-1:0] rd_ptr_q;
	logic [OQ_CW-1:0] cnt_q;
	logic [OQ_CW-1:0] push_n;
	logic [OQ_CW-1:0] hold_n;
	logic             pop;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= LINE_WIDTH_RST;
		end else if (cfg_valid && cfg_ready) begin
			line_width_q <= line_width;
		end
	end

	// column position and end-of-line decision at the input
	assign acc = in_valid && in_ready;
	assign cc = (col_q > AW'(MAX_WIDTH - 1)) ? AW'(MAX_WIDTH - 1) : col_q;
	assign lw_ext = WW'(line_width_q);

	always_comb begin
		if (lw_ext < WW'(MIN_WIDTH)) begin
			ew_m1 = WW'(MIN_WIDTH - 1);
		end else if (lw_ext > WW'(MAX_WIDTH)) begin
			ew_m1 = WW'(MAX_WIDTH - 1);
		end else begin
			ew_m1 = lw_ext - WW'(1);
		end
	end

	assign last = (WW'(cc) >= ew_m1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			line_cnt_q <= 2'd0;
			valid_s1 <= 1'b0;
			emit1_s1 <= 1'b0;
			emit2_s1 <= 1'b0;
			med_en_s1 <= 1'b0;
		end else begin
			valid_s1 <= acc;
			if (acc) begin
				emit1_s1 <= (line_cnt_q != 2'd0) && (cc != '0);
				emit2_s1 <= (line_cnt_q != 2'd0) && (cc != '0) && last;
				med_en_s1 <= (line_cnt_q == 2'd2) && (cc >= AW'(2));
				if (last) begin
					col_q <= '0;
					if (line_cnt_q != 2'd2) begin
						line_cnt_q <= line_cnt_q + 2'd1;
					end
				end else begin
					col_q <= col_q + AW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			px_s1 <= pixel_in;
			c_s1 <= cc;
		end
	end

	// line stores: read at take, written back in the cycle after
	always_ff @(posedge clk) begin
		if (acc) begin
			old_rd_s1 <= older_mem[cc];
			new_rd_s1 <= newer_mem[cc];
		end
		if (valid_s1) begin
			older_mem[c_s1] <= new_rd_s1;
			newer_mem[c_s1] <= px_s1;
		end
	end

	// window holds columns c-2 and c-1 (older, newer, input row each)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (valid_s1) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= old_rd_s1;
			win_q[4] <= new_rd_s1;
			win_q[5] <= px_s1;
		end
	end

	assign med = median9(win_q[0], win_q[3], old_rd_s1,
		win_q[1], win_q[4], new_rd_s1,
		win_q[2], win_q[5], px_s1);

	// output queue; up to two results per item
	assign push_n = valid_s1 ? (OQ_CW'(emit1_s1) + OQ_CW'(emit2_s1)) : '0;
	assign hold_n = cnt_q + (valid_s1 ? OQ_CW'(2) : '0);
	assign in_ready = (hold_n <= OQ_CW'(OQ_DEPTH - 4));
	assign out_valid = (cnt_q != '0);
	assign pop = out_valid && out_ready;
	assign pixel_out = oq_q[rd_ptr_q].value;
	assign line_end = oq_q[rd_ptr_q].line_end;

	always_ff @(posedge clk) begin
		if (valid_s1 && emit1_s1) begin
			oq_q[wr_ptr_q] <= '{value: (med_en_s1 ? med : '0), line_end: 1'b0};
			if (emit2_s1) begin
				oq_q[wr_ptr_q + OQ_PW'(1)] <= '{value: '0, line_end: 1'b1};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + OQ_PW'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OQ_PW'(1);
			end
			cnt_q <= cnt_q + push_n - OQ_CW'(pop);
		end
	end

	a_oq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= OQ_CW'(OQ_DEPTH))
		else $error("output queue overflow");

	a_take_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> valid_s1)
		else $error("taken item did not reach stage 1");

	a_second_result: assert property (@(posedge clk) disable iff (!arst_n)
		(emit2_s1 || med_en_s1) |-> emit1_s1)
		else $error("extra or median result without a first result");

	a_line_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		line_cnt_q != 2'd3)
		else $error("line count beyond saturation");

	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (cnt_q + push_n <= OQ_CW'(OQ_DEPTH)))
		else $error("push into full output queue");

endmodule
